[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file of this block.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

[hw/rtl/soa_pkg.sv]
// Types and constants of the slab object allocator.
// Depends on nothing; used by all modules of the block.
package soa_pkg;
	localparam int unsigned NUM_CLASSES = 9;
	localparam int unsigned MIN_SHIFT   = 3;
	localparam int unsigned BLK_W       = 5;
	localparam int unsigned NUM_BLOCKS  = 32;
	localparam int unsigned CLS_W       = 4;
	localparam int unsigned CNT_W       = 10;
	localparam int unsigned BLOCK_SHIFT = 12;

	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_OOM = 2'd1,
		ST_BAD = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_READ,
		FSM_CALC
	} fsm_t;

	// One class table entry: block being filled and slots used in it.
	typedef struct packed {
		logic [BLK_W-1:0] cur_block;
		logic [CNT_W-1:0] used;
	} cls_entry_t;

	// Size decode result.
	typedef struct packed {
		logic             bad;
		logic [CLS_W-1:0] cls;
	} cls_dec_t;
endpackage

[hw/rtl/soa_size_decode.sv]
// Maps a request size to its power-of-two size class; zero or above 2048 is bad.
// Depends on soa_pkg.
module soa_size_decode (
	input  logic [11:0]       object_size,
	output soa_pkg::cls_dec_t dec
);
	always_comb begin
		dec.bad = 1'b1;
		dec.cls = '0;
		if (object_size != 12'd0) begin
			for (int c = soa_pkg::NUM_CLASSES - 1; c >= 0; c--) begin
				if ({1'b0, object_size} <= (13'd1 << (soa_pkg::MIN_SHIFT + c))) begin
					dec.bad = 1'b0;
					dec.cls = soa_pkg::CLS_W'(c);
				end
			end
		end
	end
endmodule

[hw/rtl/slab_object_allocator_unit.sv]
// Top level of the slab object allocator: handshake, FSM, class table memory.
// Depends on soa_pkg and soa_size_decode.
//
//  channel      | signals                                   | direction
//  -------------+-------------------------------------------+----------
//  request      | in_valid, in_stall, object_size           | in
//  result       | out_valid, out_stall, status .. byte_off. | out
//  block count  | block_count_we, block_count_wdata         | in
//
// After an item is accepted, the class table is read in the READ state; in the
// CALC state the result is computed, written back and loaded into the result
// register; no new item is taken until the unit is back in IDLE. The
// result register frees the input side, so a new item is taken while a result
// still waits; a waiting result holds the compute stage. Reset or a write of
// the block count clears the class valid bits and rebuilds the taken-block
// mask at once; no clearing pass is needed.
module slab_object_allocator_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [11:0] object_size,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [3:0]  size_class,
	output logic [4:0]  data_block,
	output logic [8:0]  slot_index,
	output logic [16:0] byte_offset,
	input  logic        block_count_we,
	input  logic [4:0]  block_count_wdata
);
	localparam int unsigned NB = soa_pkg::NUM_BLOCKS;

	soa_pkg::fsm_t      state_q, state_d;
	soa_pkg::cls_dec_t  dec;
	soa_pkg::cls_dec_t  dec_s1;
	soa_pkg::cls_entry_t mem [soa_pkg::NUM_CLASSES];
	soa_pkg::cls_entry_t rd_s2;
	logic [soa_pkg::NUM_CLASSES-1:0] cls_valid_q;
	logic [NB-1:0]      taken_q;
	logic               accept, calc_go;

	// Compute-stage signals.
	logic [soa_pkg::CNT_W-1:0] slots;
	logic               has_free;
	logic               free_found;
	logic [soa_pkg::BLK_W-1:0] free_blk;
	logic [1:0]         res_status;
	logic [soa_pkg::BLK_W-1:0] res_blk;
	logic [8:0]         res_slot;
	logic [16:0]        res_off;
	logic               do_write, do_claim;
	soa_pkg::cls_entry_t wr_entry;

	soa_size_decode u_dec (
		.object_size(object_size),
		.dec        (dec)
	);

	assign accept = in_valid && !in_stall;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			soa_pkg::FSM_IDLE: if (in_valid) state_d = soa_pkg::FSM_READ;
			soa_pkg::FSM_READ: state_d = soa_pkg::FSM_CALC;
			soa_pkg::FSM_CALC: if (calc_go) state_d = soa_pkg::FSM_IDLE;
			default:           state_d = soa_pkg::FSM_IDLE;
		endcase
	end

	// FSM outputs.
	always_comb begin
		in_stall = (state_q != soa_pkg::FSM_IDLE);
		calc_go  = (state_q == soa_pkg::FSM_CALC) && (!out_valid || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= soa_pkg::FSM_IDLE;
		else         state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (accept) dec_s1 <= dec;
	end

	// Class table memory: one synchronous read port, one write port.
	always_ff @(posedge clk) begin
		rd_s2 <= mem[dec_s1.cls];
		if (do_write) mem[dec_s1.cls] <= wr_entry;
	end

	// Objects per block of this class.
	assign slots = soa_pkg::CNT_W'((13'd1 << soa_pkg::BLOCK_SHIFT) >>
		(soa_pkg::MIN_SHIFT + 32'(dec_s1.cls)));
	assign has_free = cls_valid_q[dec_s1.cls] && (rd_s2.used < slots);

	// Lowest free data block.
	always_comb begin
		free_found = 1'b0;
		free_blk   = '0;
		for (int b = NB - 1; b >= 0; b--) begin
			if (!taken_q[b]) begin
				free_found = 1'b1;
				free_blk   = soa_pkg::BLK_W'(b);
			end
		end
	end

	always_comb begin
		res_status = soa_pkg::ST_OK;
		res_blk    = '0;
		res_slot   = '0;
		do_write   = 1'b0;
		do_claim   = 1'b0;
		wr_entry   = rd_s2;
		if (dec_s1.bad) begin
			res_status = soa_pkg::ST_BAD;
		end else if (has_free) begin
			res_blk        = rd_s2.cur_block;
			res_slot       = rd_s2.used[8:0];
			wr_entry.used  = rd_s2.used + soa_pkg::CNT_W'(1);
			do_write       = calc_go;
		end else if (free_found) begin
			res_blk            = free_blk;
			wr_entry.cur_block = free_blk;
			wr_entry.used      = soa_pkg::CNT_W'(1);
			do_write           = calc_go;
			do_claim           = calc_go;
		end else begin
			res_status = soa_pkg::ST_OOM;
		end
		res_off = ({12'd0, res_blk} << soa_pkg::BLOCK_SHIFT) +
			17'(({8'd0, res_slot} << (soa_pkg::MIN_SHIFT + 32'(dec_s1.cls))));
	end

	// Taken-block mask and class valid bits; a count write rebuilds them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taken_q     <= ~((NB'(1) << 31) - NB'(1));
			cls_valid_q <= '0;
		end else if (block_count_we) begin
			taken_q     <= ~((NB'(1) << block_count_wdata) - NB'(1));
			cls_valid_q <= '0;
		end else if (do_write) begin
			cls_valid_q[dec_s1.cls] <= 1'b1;
			if (do_claim) taken_q[free_blk] <= 1'b1;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)                   out_valid <= 1'b0;
		else if (calc_go)              out_valid <= 1'b1;
		else if (out_valid && !out_stall) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (calc_go) begin
			status      <= res_status;
			size_class  <= dec_s1.bad ? '0 : dec_s1.cls;
			data_block  <= res_blk;
			slot_index  <= res_slot;
			byte_offset <= res_off;
		end
	end
endmodule

[hw/rtl/soa_checker.sv]
// Port-level checks of the slab object allocator, bound to the top level.
// Depends on assert_macros.svh and soa_pkg.
`include "assert_macros.svh"
module soa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic [3:0]  size_class,
	input logic [4:0]  data_block,
	input logic [8:0]  slot_index,
	input logic [16:0] byte_offset
);
	`ASSERT_IMPL(a_bad_zero, clk, arst_n, out_valid && status == soa_pkg::ST_BAD, {size_class, data_block, byte_offset} == '0)
	`ASSERT_IMPL(a_oom_zero, clk, arst_n, out_valid && status == soa_pkg::ST_OOM, {data_block, slot_index, byte_offset} == '0)
	`ASSERT_IMPL(a_offset, clk, arst_n, out_valid && status == soa_pkg::ST_OK, byte_offset[16:12] == data_block)
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(byte_offset))
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)
endmodule

bind slab_object_allocator_unit soa_checker u_soa_checker (.*);

[tb/testbench.sv]
// Self-checking testbench for slab_object_allocator_unit.
// Depends on soa_pkg and the allocator RTL; a built-in predictor of the
// class, block and slot choices checks every result item in order.
`timescale 1ns / 1ps

module testbench;
	// One expected result item, at the widths of the result ports.
	typedef struct packed {
		soa_pkg::status_t st;
		logic [3:0]  cls;
		logic [4:0]  blk;
		logic [8:0]  slot;
		logic [16:0] offs;
	} alloc_result_t;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int LONG_HOLD      = 300;
	localparam int DRAIN_CYCLES   = 12;
	localparam int NUM_DIRECTED   = 20;

	// Class edges, bad sizes and refills of the largest class.
	localparam logic [11:0] DIRECTED_SIZES [NUM_DIRECTED] = '{12'd0, 12'd1, 12'd8,
		12'd9, 12'd16, 12'd17, 12'd32, 12'd64, 12'd128, 12'd256, 12'd512, 12'd1024,
		12'd1025, 12'd2047, 12'd2048, 12'd2049, 12'd4095, 12'd2048, 12'd2048, 12'd8};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [11:0] object_size;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic [3:0]  size_class;
	logic [4:0]  data_block;
	logic [8:0]  slot_index;
	logic [16:0] byte_offset;
	logic        block_count_we;
	logic [4:0]  block_count_wdata;

	slab_object_allocator_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.object_size(object_size),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.size_class(size_class),
		.data_block(data_block),
		.slot_index(slot_index),
		.byte_offset(byte_offset),
		.block_count_we(block_count_we),
		.block_count_wdata(block_count_wdata)
	);

	// Requests waiting to be offered, and results the predictor expects.
	logic [11:0]   request_queue[$];
	alloc_result_t alloc_expected[$];

	// Predictor copy of the allocator state.
	logic [31:0]  taken_mask;
	logic [31:0]  owned_mask[soa_pkg::NUM_CLASSES];
	logic [511:0] slot_map[32][soa_pkg::NUM_CLASSES];

	int  send_idle_pct;
	int  stall_pct;
	int  hold_left;
	bit  hold_request;
	bit  in_took;
	int  quiet_cycles;
	int  mismatches;
	int  results_seen;
	int  ok_seen;
	int  oom_seen;
	int  bad_seen;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Clear every map; blocks at or above the count start out taken.
	function automatic void format_predictor(logic [4:0] count);
		taken_mask = ~((32'd1 << count) - 32'd1);
		for (int c = 0; c < soa_pkg::NUM_CLASSES; c++) begin
			owned_mask[c] = '0;
			for (int b = 0; b < 32; b++)
				slot_map[b][c] = '0;
		end
	endfunction

	// Work out the result of one allocation request and update the maps.
	function automatic alloc_result_t predict_alloc(logic [11:0] req);
		alloc_result_t r;
		int cls;
		int slots;
		int blk;
		int slot;
		r = '0;
		cls = -1;
		blk = 0;
		slot = -1;
		if (req != 0) begin
			for (int c = 0; c < soa_pkg::NUM_CLASSES; c++) begin
				if (cls < 0 && req <= (12'd8 << c))
					cls = c;
			end
		end
		if (cls < 0) begin
			r.st = soa_pkg::ST_BAD;
			return r;
		end
		r.cls = cls[3:0];
		slots = 512 >> cls;
		// Owned blocks are searched lowest first, then the lowest free slot.
		for (int b = 0; b < 32 && slot < 0; b++) begin
			if (owned_mask[cls][b]) begin
				for (int s = 0; s < slots && slot < 0; s++) begin
					if (!slot_map[b][cls][s]) begin
						slot = s;
						blk = b;
					end
				end
			end
		end
		// Otherwise the lowest free block is claimed and slot 0 handed out.
		if (slot < 0) begin
			for (int b = 0; b < 32 && slot < 0; b++) begin
				if (!taken_mask[b]) begin
					taken_mask[b] = 1'b1;
					owned_mask[cls][b] = 1'b1;
					blk = b;
					slot = 0;
				end
			end
		end
		if (slot < 0) begin
			r.st = soa_pkg::ST_OOM;
			return r;
		end
		slot_map[blk][cls][slot] = 1'b1;
		r.st = soa_pkg::ST_OK;
		r.blk = blk[4:0];
		r.slot = slot[8:0];
		r.offs = 17'((blk << 12) + (slot << (soa_pkg::MIN_SHIFT + cls)));
		return r;
	endfunction

	// A well-formed request of a random class, now and then a raw 12-bit value.
	function automatic logic [11:0] random_request();
		int c;
		int lo;
		if ($urandom_range(99) < 10)
			return 12'($urandom_range(0, 4095));
		c = $urandom_range(0, soa_pkg::NUM_CLASSES - 1);
		lo = (c == 0) ? 1 : (4 << c) + 1;
		return 12'($urandom_range(lo, 8 << c));
	endfunction

	// Sender: a new item goes out only when the previous one was taken.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_took) begin
			// The stalled item stays as it is.
		end else if (request_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
			in_valid <= 1'b1;
			object_size <= request_queue.pop_front();
		end else begin
			in_valid <= 1'b0;
		end
	end

	// Receiver: random stalls, plus one long hold-off counted here.
	always @(negedge clk) begin
		if (hold_request && hold_left == 0) begin
			hold_request = 1'b0;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Monitor: checks accepted results, then predicts for an accepted request.
	always @(posedge clk) begin
		alloc_result_t exp_r;
		bit any_taken;
		any_taken = 1'b0;
		in_took = 1'b0;
		if (arst_n && out_valid && !out_stall) begin
			any_taken = 1'b1;
			results_seen++;
			if (alloc_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result item with nothing expected: status %0d block %0d",
						status, data_block);
			end else begin
				exp_r = alloc_expected.pop_front();
				case (exp_r.st)
					soa_pkg::ST_OK:  ok_seen++;
					soa_pkg::ST_OOM: oom_seen++;
					default:         bad_seen++;
				endcase
				if (status != exp_r.st || size_class != exp_r.cls ||
						data_block != exp_r.blk || slot_index != exp_r.slot ||
						byte_offset != exp_r.offs) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: expected st %0d cls %0d blk %0d slot %0d ",
							"off %0d, got st %0d cls %0d blk %0d slot %0d off %0d"},
							exp_r.st, exp_r.cls, exp_r.blk, exp_r.slot, exp_r.offs,
							status, size_class, data_block, slot_index, byte_offset);
				end
			end
		end
		if (arst_n && in_valid && !in_stall) begin
			any_taken = 1'b1;
			in_took = 1'b1;
			alloc_expected.push_back(predict_alloc(object_size));
		end
		// The watchdog only runs while work is outstanding.
		if (any_taken || (request_queue.size() == 0 && alloc_expected.size() == 0 && !in_valid))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Wait until every request is out and every result is back.
	task automatic wait_drained();
		while (request_queue.size() > 0 || in_valid || alloc_expected.size() > 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Write the block count while the block is idle; it clears all maps.
	task automatic write_block_count(logic [4:0] count);
		@(negedge clk);
		block_count_we <= 1'b1;
		block_count_wdata <= count;
		format_predictor(count);
		@(negedge clk);
		block_count_we <= 1'b0;
	endtask

	task automatic run_random_phase(logic [4:0] count, int send_pct, int recv_pct, int n);
		write_block_count(count);
		send_idle_pct = send_pct;
		stall_pct = recv_pct;
		for (int i = 0; i < n; i++)
			request_queue.push_back(random_request());
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		object_size = '0;
		out_stall = 1'b0;
		block_count_we = 1'b0;
		block_count_wdata = '0;
		send_idle_pct = 0;
		stall_pct = 0;
		hold_left = 0;
		hold_request = 1'b0;
		in_took = 1'b0;
		quiet_cycles = 0;
		mismatches = 0;
		results_seen = 0;
		ok_seen = 0;
		oom_seen = 0;
		bad_seen = 0;
		format_predictor(5'd31);
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part on the reset count: class edges, bad sizes, refills.
		for (int i = 0; i < NUM_DIRECTED; i++)
			request_queue.push_back(DIRECTED_SIZES[i]);
		wait_drained();

		// Zero count: every valid request runs out of memory.
		write_block_count(5'd0);
		request_queue.push_back(12'd1);
		request_queue.push_back(12'd2048);
		request_queue.push_back(12'd0);
		wait_drained();

		// One block: two large objects fit, the third does not.
		write_block_count(5'd1);
		repeat (3) request_queue.push_back(12'd2048);
		request_queue.push_back(12'd4);
		wait_drained();

		// Random phases across idle patterns and block counts.
		run_random_phase(5'd31, 0, 0, 80);
		run_random_phase(5'd2, 65, 0, 70);
		run_random_phase(5'd5, 0, 65, 70);
		run_random_phase(5'd17, 38, 38, 80);

		// Long receiver hold-off while the sender keeps offering items.
		write_block_count(5'd3);
		send_idle_pct = 0;
		stall_pct = 0;
		for (int i = 0; i < 40; i++)
			request_queue.push_back(random_request());
		hold_request = 1'b1;
		wait_drained();
		run_random_phase(5'd31, 0, 0, 60);

		$display("Covered %0d result items (%0d allocated, %0d out of memory, %0d bad size)",
			results_seen, ok_seen, oom_seen, bad_seen);
		$display("over block counts 0 to 31 with sender gaps, receiver stalls and a long hold-off.");
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule

[slab_object_allocator_unit.f]
+incdir+hw/rtl
hw/rtl/soa_pkg.sv
hw/rtl/soa_size_decode.sv
hw/rtl/slab_object_allocator_unit.sv
hw/rtl/soa_checker.sv
tb/testbench.sv
